// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the touch calibration block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tsca_pkg.sv
// Shared types, constants and a helper function of the touch calibration block.
package tsca_pkg;

   // Field widths
   localparam int RAW_W   = 12;
   localparam int PRESS_W = 13;
   localparam int RES_W   = 11;
   localparam int POINT_W = 10;
   localparam int MODE_W  = 4;
   localparam int AXES    = 2;

   // Scaling product and the quotient bits developed by the mapping divider
   localparam int PROD_W = RAW_W + POINT_W;
   localparam int QUO_W  = RES_W;
   localparam int HI_W   = PROD_W - QUO_W;

   // Pressure bias and resolution limits
   localparam logic [PRESS_W-1:0] PRESS_BIAS = 13'd4096;
   localparam logic [RES_W-1:0]   RES_MIN    = 11'd1;
   localparam logic [RES_W-1:0]   RES_MAX    = 11'd1024;

   // Largest averaged point value
   localparam int POINT_MAX = 1023;

   localparam int DEFAULT_AVERAGE_DEPTH = 4;

   // Register file port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_PRESS_THRESHOLD,
      CSR_X_RAW_MIN,
      CSR_X_RAW_MAX,
      CSR_Y_RAW_MIN,
      CSR_Y_RAW_MAX,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_MODE_FLAGS
   } csr_index_type;

   // Register reset values
   localparam logic [PRESS_W-1:0] RST_PRESS_THRESHOLD = 13'd400;
   localparam logic [RAW_W-1:0]   RST_X_RAW_MIN       = 12'd200;
   localparam logic [RAW_W-1:0]   RST_X_RAW_MAX       = 12'd3700;
   localparam logic [RAW_W-1:0]   RST_Y_RAW_MIN       = 12'd240;
   localparam logic [RAW_W-1:0]   RST_Y_RAW_MAX       = 12'd3800;
   localparam logic [RES_W-1:0]   RST_SCREEN_WIDTH    = 11'd320;
   localparam logic [RES_W-1:0]   RST_SCREEN_HEIGHT   = 11'd240;
   localparam logic [MODE_W-1:0]  RST_MODE_FLAGS      = 4'd0;

   // Bit positions in mode_flags
   localparam int MODE_SWAP     = 0;
   localparam int MODE_INVERT_X = 1;
   localparam int MODE_INVERT_Y = 2;
   localparam int MODE_USE_PEN  = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_LOAD,
      ST_DIVIDE,
      ST_MAP,
      ST_AVERAGE,
      ST_REPLY
   } state_type;

   // Calibration of one axis
   typedef struct packed {
      logic [RAW_W-1:0] lo;
      logic [RAW_W-1:0] hi;
      logic [RES_W-1:0] res;
      logic             invert;
   } axis_cfg_type;

   // Resolution as used: zero counts as one, anything above the maximum as the maximum.
   function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
      logic [RES_W-1:0] v;
      v = r;
      if (r < RES_MIN) begin
         v = RES_MIN;
      end else if (r > RES_MAX) begin
         v = RES_MAX;
      end
      return v;
   endfunction

endpackage

// File: rtl/tsca_if.sv
// Request and response channel interfaces of the touch calibration block.
interface tsca_req_if
   import tsca_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               pen_line;
   logic [RAW_W-1:0]   pressure_one;
   logic [RAW_W-1:0]   pressure_two;
   logic [RAW_W-1:0]   raw_x;
   logic [RAW_W-1:0]   raw_y;

   modport source (
      output valid, pen_line, pressure_one, pressure_two, raw_x, raw_y,
      input  ready
   );
   modport sink (
      input  valid, pen_line, pressure_one, pressure_two, raw_x, raw_y,
      output ready
   );
endinterface

interface tsca_rsp_if
   import tsca_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               pressed;
   logic [POINT_W-1:0] point_x;
   logic [POINT_W-1:0] point_y;

   modport source (
      output valid, pressed, point_x, point_y,
      input  ready
   );
   modport sink (
      input  valid, pressed, point_x, point_y,
      output ready
   );
endinterface

// File: rtl/touch_sample_calibrate_average.sv
// Top level of the touch calibration block: pressure check, axis mapping and averaging.
//
// Each request is one poll of a resistive panel. A poll that shows no touch
// goes from accept straight to the reply state; it clears the average and
// repeats the last point. A touch is worked by two bit-serial restoring
// dividers that run one after the other: eleven steps that scale both axes in
// parallel by resolution/(max-min), then SUM_W steps that divide the running
// sums by the fill count, SUM_W being the width of the running sum ($clog2 of
// AVERAGE_DEPTH*1023+1; 12 at the default depth of four). No new request is
// accepted until the current one has been answered. The scaling product
// itself comes from one registered multiplier per axis. The history lines
// are shift registers with a running sum, so a push costs the same at any
// depth. The response register lets a new request be accepted while the
// previous response still waits to be taken. Configuration goes through an
// APB-style port with registers at byte address 4*index; the user must write
// it only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module touch_sample_calibrate_average
   import tsca_pkg::*;
#(
   parameter int unsigned AVERAGE_DEPTH = DEFAULT_AVERAGE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   tsca_req_if.sink              req_if,
   tsca_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CNT_W    = $clog2(AVERAGE_DEPTH + 1);
   localparam int SUM_W    = $clog2(AVERAGE_DEPTH * POINT_MAX + 1);
   localparam int STEP_MAX = (SUM_W > QUO_W) ? SUM_W : QUO_W;
   localparam int STEP_W   = $clog2(STEP_MAX);

   // Configuration registers
   logic [PRESS_W-1:0] press_threshold_ff;
   logic [RAW_W-1:0]   x_raw_min_ff;
   logic [RAW_W-1:0]   x_raw_max_ff;
   logic [RAW_W-1:0]   y_raw_min_ff;
   logic [RAW_W-1:0]   y_raw_max_ff;
   logic [RES_W-1:0]   screen_width_ff;
   logic [RES_W-1:0]   screen_height_ff;
   logic [MODE_W-1:0]  mode_flags_ff;

   // Control state
   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               touch_ff, touch_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-axis datapath
   logic [RAW_W-1:0]   off_ff[AXES], off_in[AXES];
   logic [PROD_W-1:0]  prod_ff[AXES], prod_in[AXES];
   logic [RAW_W-1:0]   rem_ff[AXES], rem_in[AXES];
   logic [QUO_W-1:0]   quo_ff[AXES], quo_in[AXES];
   logic               big_ff[AXES], big_in[AXES];
   logic [SUM_W-1:0]   sum_ff[AXES], sum_in[AXES];
   logic [CNT_W-1:0]   avg_rem_ff[AXES], avg_rem_in[AXES];
   logic [SUM_W-1:0]   avg_sh_ff[AXES], avg_sh_in[AXES];
   logic [POINT_W-1:0] held_ff[AXES], held_in[AXES];
   logic [POINT_W-1:0] hist_ff[AXES][AVERAGE_DEPTH];
   logic               rsp_pressed_ff;
   logic [POINT_W-1:0] rsp_point_ff[AXES];

   // Combinational helpers
   axis_cfg_type       acfg[AXES];
   logic [RAW_W-1:0]   span[AXES];
   logic               span_zero[AXES];
   logic               span_neg[AXES];
   logic [POINT_W-1:0] pt[AXES];
   logic               csr_write;
   csr_index_type      csr_index;
   logic               req_ready;
   logic               req_fire;
   logic               touch_now;
   logic               out_free;
   logic               fill_full;

   //---------------------------------------------------------------------
   // Register file
   //---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_threshold_ff <= RST_PRESS_THRESHOLD;
         x_raw_min_ff       <= RST_X_RAW_MIN;
         x_raw_max_ff       <= RST_X_RAW_MAX;
         y_raw_min_ff       <= RST_Y_RAW_MIN;
         y_raw_max_ff       <= RST_Y_RAW_MAX;
         screen_width_ff    <= RST_SCREEN_WIDTH;
         screen_height_ff   <= RST_SCREEN_HEIGHT;
         mode_flags_ff      <= RST_MODE_FLAGS;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PRESS_THRESHOLD: press_threshold_ff <= pwdata[PRESS_W-1:0];
            CSR_X_RAW_MIN:       x_raw_min_ff       <= pwdata[RAW_W-1:0];
            CSR_X_RAW_MAX:       x_raw_max_ff       <= pwdata[RAW_W-1:0];
            CSR_Y_RAW_MIN:       y_raw_min_ff       <= pwdata[RAW_W-1:0];
            CSR_Y_RAW_MAX:       y_raw_max_ff       <= pwdata[RAW_W-1:0];
            CSR_SCREEN_WIDTH:    screen_width_ff    <= pwdata[RES_W-1:0];
            CSR_SCREEN_HEIGHT:   screen_height_ff   <= pwdata[RES_W-1:0];
            CSR_MODE_FLAGS:      mode_flags_ff      <= pwdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register.
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         CSR_PRESS_THRESHOLD: prdata = CSR_DATA_W'(press_threshold_ff);
         CSR_X_RAW_MIN:       prdata = CSR_DATA_W'(x_raw_min_ff);
         CSR_X_RAW_MAX:       prdata = CSR_DATA_W'(x_raw_max_ff);
         CSR_Y_RAW_MIN:       prdata = CSR_DATA_W'(y_raw_min_ff);
         CSR_Y_RAW_MAX:       prdata = CSR_DATA_W'(y_raw_max_ff);
         CSR_SCREEN_WIDTH:    prdata = CSR_DATA_W'(screen_width_ff);
         CSR_SCREEN_HEIGHT:   prdata = CSR_DATA_W'(screen_height_ff);
         CSR_MODE_FLAGS:      prdata = CSR_DATA_W'(mode_flags_ff);
         default:             prdata = '0;
      endcase
   end

   // Per-axis calibration and span classification.
   always_comb begin
      acfg[0] = '{lo: x_raw_min_ff, hi: x_raw_max_ff, res: eff_res(screen_width_ff),
                  invert: mode_flags_ff[MODE_INVERT_X]};
      acfg[1] = '{lo: y_raw_min_ff, hi: y_raw_max_ff, res: eff_res(screen_height_ff),
                  invert: mode_flags_ff[MODE_INVERT_Y]};
      for (int a = 0; a < AXES; a++) begin
         span[a]      = acfg[a].hi - acfg[a].lo;
         span_zero[a] = (acfg[a].hi == acfg[a].lo);
         span_neg[a]  = (acfg[a].hi < acfg[a].lo);
      end
   end

   //---------------------------------------------------------------------
   // Control state machine
   //---------------------------------------------------------------------
   always_comb begin
      logic [PRESS_W-1:0] pressure;
      pressure  = PRESS_W'(req_if.pressure_one) + PRESS_BIAS - PRESS_W'(req_if.pressure_two);
      touch_now = !(mode_flags_ff[MODE_USE_PEN] && req_if.pen_line)
                  && (pressure >= press_threshold_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) state_in = touch_now ? ST_MULT : ST_REPLY;
         ST_MULT:    state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_DIVIDE;
         ST_DIVIDE:  if (step_ff == STEP_W'(QUO_W - 1)) state_in = ST_MAP;
         ST_MAP:     state_in = ST_AVERAGE;
         ST_AVERAGE: if (step_ff == STEP_W'(SUM_W - 1)) state_in = ST_REPLY;
         ST_REPLY:   if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // State machine outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      out_free  = !rsp_valid_ff || rsp_if.ready;
   end

   assign req_if.ready = req_ready;
   assign req_fire     = req_if.valid && req_ready;

   //---------------------------------------------------------------------
   // Datapath next values
   //---------------------------------------------------------------------
   assign fill_full = (fill_ff == CNT_W'(AVERAGE_DEPTH));

   always_comb begin
      logic [RAW_W-1:0]   raw[AXES];
      logic [PROD_W-1:0]  prod_full;
      logic [HI_W-1:0]    hi_part;
      logic [RAW_W:0]     r2;
      logic               ge;
      logic [CNT_W:0]     ar2;
      logic               age;
      logic [QUO_W-1:0]   q;
      logic [RES_W-1:0]   res;
      logic [RES_W-1:0]   v;
      logic               over;
      logic [POINT_W-1:0] evict;

      step_in      = step_ff;
      touch_in     = touch_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      // Optional axis swap on the raw point
      raw[0] = mode_flags_ff[MODE_SWAP] ? req_if.raw_y : req_if.raw_x;
      raw[1] = mode_flags_ff[MODE_SWAP] ? req_if.raw_x : req_if.raw_y;

      for (int a = 0; a < AXES; a++) begin
         off_in[a]     = off_ff[a];
         prod_in[a]    = prod_ff[a];
         rem_in[a]     = rem_ff[a];
         quo_in[a]     = quo_ff[a];
         big_in[a]     = big_ff[a];
         sum_in[a]     = sum_ff[a];
         avg_rem_in[a] = avg_rem_ff[a];
         avg_sh_in[a]  = avg_sh_ff[a];
         held_in[a]    = held_ff[a];

         // Clamp of the scaled value to the screen, with optional inversion
         q    = quo_ff[a];
         res  = acfg[a].res;
         over = big_ff[a] || (q >= res);
         if (span_neg[a]) begin
            v = acfg[a].invert ? res - RES_W'(1) : '0;
         end else if (over) begin
            v = acfg[a].invert ? '0 : res - RES_W'(1);
         end else if (acfg[a].invert) begin
            v = (q == '0) ? res - RES_W'(1) : res - q;
         end else begin
            v = q;
         end
         pt[a] = v[POINT_W-1:0];

         prod_full = PROD_W'(off_ff[a]) * PROD_W'(res);
         hi_part   = prod_ff[a][PROD_W-1:QUO_W];
         r2        = {rem_ff[a], quo_ff[a][QUO_W-1]};
         ge        = (r2 >= {1'b0, span[a]});
         ar2       = {avg_rem_ff[a], avg_sh_ff[a][SUM_W-1]};
         age       = (ar2 >= {1'b0, fill_ff});
         evict     = fill_full ? hist_ff[a][AVERAGE_DEPTH-1] : '0;

         unique case (state_ff)
            ST_IDLE: begin
               // Offset by the minimum, with a floor at zero
               off_in[a] = (raw[a] > acfg[a].lo) ? raw[a] - acfg[a].lo : '0;
               if (req_fire && !touch_now) begin
                  sum_in[a] = '0;
               end
            end
            ST_MULT: begin
               prod_in[a] = prod_full;
            end
            ST_LOAD: begin
               // A high part at or above the span means a quotient beyond any screen
               rem_in[a] = RAW_W'(hi_part);
               quo_in[a] = prod_ff[a][QUO_W-1:0];
               big_in[a] = span_zero[a] || (RAW_W'(hi_part) >= span[a]);
            end
            ST_DIVIDE: begin
               rem_in[a] = ge ? RAW_W'(r2 - {1'b0, span[a]}) : r2[RAW_W-1:0];
               quo_in[a] = {quo_ff[a][QUO_W-2:0], ge};
            end
            ST_MAP: begin
               // Running sum over the history line: add the new point, drop the oldest
               sum_in[a]     = sum_ff[a] + SUM_W'(pt[a]) - SUM_W'(evict);
               avg_rem_in[a] = '0;
               avg_sh_in[a]  = sum_in[a];
            end
            ST_AVERAGE: begin
               avg_rem_in[a] = age ? CNT_W'(ar2 - {1'b0, fill_ff}) : ar2[CNT_W-1:0];
               avg_sh_in[a]  = {avg_sh_ff[a][SUM_W-2:0], age};
            end
            ST_REPLY: begin
               if (out_free && touch_ff) begin
                  held_in[a] = avg_sh_ff[a][POINT_W-1:0];
               end
            end
            default: ;
         endcase
      end

      // Shared control of the two axes
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               touch_in = touch_now;
               if (!touch_now) begin
                  fill_in = '0;
               end
            end
         end
         ST_LOAD:    step_in = '0;
         ST_DIVIDE:  step_in = step_ff + STEP_W'(1);
         ST_MAP: begin
            step_in = '0;
            fill_in = fill_full ? fill_ff : fill_ff + CNT_W'(1);
         end
         ST_AVERAGE: step_in = step_ff + STEP_W'(1);
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   //---------------------------------------------------------------------
   // Registers
   //---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         touch_ff     <= 1'b0;
         step_ff      <= '0;
         for (int a = 0; a < AXES; a++) begin
            held_ff[a] <= '0;
            sum_ff[a]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         touch_ff     <= touch_in;
         step_ff      <= step_in;
         for (int a = 0; a < AXES; a++) begin
            held_ff[a] <= held_in[a];
            sum_ff[a]  <= sum_in[a];
         end
      end
   end

   // Divider and averaging datapath registers
   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         off_ff[a]     <= off_in[a];
         prod_ff[a]    <= prod_in[a];
         rem_ff[a]     <= rem_in[a];
         quo_ff[a]     <= quo_in[a];
         big_ff[a]     <= big_in[a];
         avg_rem_ff[a] <= avg_rem_in[a];
         avg_sh_ff[a]  <= avg_sh_in[a];
      end
   end

   // History lines: newest point enters at the head on every touch
   always_ff @(posedge clock) begin
      if (state_ff == ST_MAP) begin
         for (int a = 0; a < AXES; a++) begin
            for (int i = AVERAGE_DEPTH - 1; i > 0; i--) begin
               hist_ff[a][i] <= hist_ff[a][i-1];
            end
            hist_ff[a][0] <= pt[a];
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_REPLY && out_free) begin
         rsp_pressed_ff <= touch_ff;
         for (int a = 0; a < AXES; a++) begin
            rsp_point_ff[a] <= held_in[a];
         end
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.pressed = rsp_pressed_ff;
   assign rsp_if.point_x = rsp_point_ff[0];
   assign rsp_if.point_y = rsp_point_ff[1];

   //---------------------------------------------------------------------
   // Assertions
   //---------------------------------------------------------------------
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= CNT_W'(AVERAGE_DEPTH),
      "fill count beyond the history depth")
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != ST_IDLE,
      "accepted request did not start work")
   `ASSERT_IMPLY(a_avg_rem_bound, clock, reset, state_ff == ST_AVERAGE,
      (avg_rem_ff[0] < fill_ff) && (avg_rem_ff[1] < fill_ff),
      "averaging remainder not below the fill count")
   `ASSERT_IMPLY(a_rsp_from_reply, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_REPLY, "response raised outside the reply state")

endmodule
